[rtl/prrt_pkg.sv]
// Shared types and defaults for the page range reference count tracker.
// No dependencies; every other file imports this package.
package prrt_pkg;

    localparam int unsigned DefPageBits      = 12;
    localparam int unsigned DefTrackedPages  = 4096;
    localparam int unsigned DefMaxRangePages = 128;
    localparam int unsigned DefCountBits     = 16;

    localparam int unsigned StartW  = 12;   // start page field
    localparam int unsigned LenW    = 20;   // byte length field
    localparam int unsigned RunW    = 8;    // run length field
    localparam int unsigned WalkW   = 13;   // walk page, start plus range
    localparam int unsigned QDepth  = 2;    // command queue depth

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_LEN = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic {
        CMD_OCCUPY  = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd_op;

    // Classified request passed from front to back.
    typedef struct packed {
        t_cmd_op            op;
        logic [StartW-1:0]  start;
        logic [RunW-1:0]    npages;
        t_status            status;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_WALK,
        BS_FLUSH,
        BS_ERR
    } t_back_state;

endpackage

[rtl/prrt_front.sv]
// Front end: accepts requests, rounds the length to pages, checks the range,
// and queues classified commands for the back end. Depends on prrt_pkg.
module prrt_front #(
    parameter int unsigned PAGE_BITS       = prrt_pkg::DefPageBits,
    parameter int unsigned TRACKED_PAGES   = prrt_pkg::DefTrackedPages,
    parameter int unsigned MAX_RANGE_PAGES = prrt_pkg::DefMaxRangePages
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_command,
    input  logic [prrt_pkg::StartW-1:0]   i_start_page,
    input  logic [prrt_pkg::LenW-1:0]     i_length_bytes,
    input  logic                          i_hold,
    output logic                          o_cmd_valid,
    output prrt_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_pop
);
    import prrt_pkg::*;

    localparam int unsigned SumW = LenW + 2;

    logic [SumW-1:0] w_round;
    logic [SumW-1:0] w_pages;
    logic [SumW-1:0] w_end;
    t_cmd            w_cmd;
    logic            w_push;

    t_cmd            r_q [QDepth];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    always_comb begin
        w_round = SumW'(i_length_bytes) + SumW'((64'd1 << PAGE_BITS) - 64'd1);
        w_pages = w_round >> PAGE_BITS;
        w_end   = SumW'(i_start_page) + w_pages;
        w_cmd.op     = t_cmd_op'(i_command);
        w_cmd.start  = i_start_page;
        w_cmd.npages = RunW'(w_pages);
        if (i_length_bytes == '0) begin
            w_cmd.status = ST_ZERO_LEN;
        end else if (w_pages > SumW'(MAX_RANGE_PAGES) || w_end > SumW'(TRACKED_PAGES)) begin
            w_cmd.status = ST_RANGE;
        end else begin
            w_cmd.status = ST_OK;
        end
    end

    assign o_full      = (r_cnt == 2'(QDepth)) || i_hold;
    assign w_push      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop && o_cmd_valid) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, i_cmd_pop && o_cmd_valid})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/prrt_back.sv]
// Back end: clears the count table after reset, walks each range one page a
// cycle unless a held result stalls it, with a read-modify-write pipeline, and
// coalesces transitions into runs. Depends on prrt_pkg.
module prrt_back #(
    parameter int unsigned TRACKED_PAGES = prrt_pkg::DefTrackedPages,
    parameter int unsigned COUNT_BITS    = prrt_pkg::DefCountBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  prrt_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_clearing,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [prrt_pkg::StartW-1:0]   o_run_start,
    output logic [prrt_pkg::RunW-1:0]     o_run_pages,
    output logic [1:0]                    o_status,
    output logic                          o_last
);
    import prrt_pkg::*;

    localparam int unsigned AW = $clog2(TRACKED_PAGES);
    localparam logic signed [COUNT_BITS-1:0] CountMax = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CountMin = {1'b1, {(COUNT_BITS-1){1'b0}}};

    t_back_state r_state, n_state;

    logic signed [COUNT_BITS-1:0] r_mem [TRACKED_PAGES];
    logic signed [COUNT_BITS-1:0] r_rdata;

    logic [AW-1:0]      r_clr;
    logic [WalkW-1:0]   r_rd_page, n_rd_page;
    logic [RunW-1:0]    r_rd_left, n_rd_left;
    logic               r_dv, n_dv;
    logic [WalkW-1:0]   r_cur, n_cur;
    t_cmd_op            r_op, n_op;
    t_status            r_status, n_status;
    logic [StartW-1:0]  r_run_start, n_run_start;
    logic [RunW-1:0]    r_run_len, n_run_len;
    logic               r_prev_x, n_prev_x;

    logic               r_ov;
    logic [StartW-1:0]  r_o_start;
    logic [RunW-1:0]    r_o_pages;
    t_status            r_o_status;
    logic               r_o_last;

    logic                         w_clear_done;
    logic                         w_crossed;
    logic signed [COUNT_BITS-1:0] w_new;
    logic                         w_need_emit;
    logic                         w_emit_ok;
    logic                         w_stall;
    logic                         w_rd_en;
    logic                         w_wr_en;
    logic [AW-1:0]                w_wr_addr;
    logic signed [COUNT_BITS-1:0] w_wr_data;
    logic                         w_emit;
    logic [StartW-1:0]            w_e_start;
    logic [RunW-1:0]              w_e_pages;
    t_status                      w_e_status;
    logic                         w_e_last;

    // Per-page update and transition detect.
    always_comb begin
        if (r_op == CMD_RELEASE) begin
            w_new     = (r_rdata == CountMin) ? r_rdata : r_rdata - COUNT_BITS'(1);
            w_crossed = (r_rdata == COUNT_BITS'(1));
        end else begin
            w_new     = (r_rdata == CountMax) ? r_rdata : r_rdata + COUNT_BITS'(1);
            w_crossed = (r_rdata == '0);
        end
    end

    assign w_clear_done = (r_clr == AW'(TRACKED_PAGES - 1));
    assign w_emit_ok    = !r_ov || i_pop;
    assign w_need_emit  = (r_state == BS_WALK) && r_dv && w_crossed && !r_prev_x
                          && (r_run_len != '0);
    assign w_stall      = w_need_emit && !w_emit_ok;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            BS_CLEAR: begin
                if (w_clear_done) n_state = BS_IDLE;
            end
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.status == ST_OK) ? BS_WALK : BS_ERR;
                end
            end
            BS_WALK: begin
                if (!w_stall && r_rd_left == '0) n_state = BS_FLUSH;
            end
            BS_FLUSH, BS_ERR: begin
                if (w_emit_ok) n_state = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // Control outputs of the state machine.
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_clearing = 1'b0;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = AW'(r_cur);
        w_wr_data  = w_new;
        w_emit     = 1'b0;
        w_e_start  = r_run_start;
        w_e_pages  = r_run_len;
        w_e_status = ST_OK;
        w_e_last   = 1'b0;
        unique case (r_state)
            BS_CLEAR: begin
                o_clearing = 1'b1;
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr;
                w_wr_data  = '0;
            end
            BS_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            BS_WALK: begin
                w_rd_en = !w_stall && (r_rd_left != '0);
                w_wr_en = !w_stall && r_dv;
                w_emit  = w_need_emit;
            end
            BS_FLUSH: begin
                w_emit   = 1'b1;
                w_e_last = 1'b1;
                if (r_run_len == '0) w_e_start = '0;
            end
            BS_ERR: begin
                w_emit     = 1'b1;
                w_e_start  = '0;
                w_e_pages  = '0;
                w_e_status = r_status;
                w_e_last   = 1'b1;
            end
            default: ;
        endcase
    end

    // Walk datapath.
    always_comb begin
        n_rd_page   = r_rd_page;
        n_rd_left   = r_rd_left;
        n_dv        = r_dv;
        n_cur       = r_cur;
        n_op        = r_op;
        n_status    = r_status;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_prev_x    = r_prev_x;
        if (o_cmd_pop) begin
            n_rd_page   = WalkW'(i_cmd.start);
            n_rd_left   = i_cmd.npages;
            n_dv        = 1'b0;
            n_op        = i_cmd.op;
            n_status    = i_cmd.status;
            n_run_start = '0;
            n_run_len   = '0;
            n_prev_x    = 1'b0;
        end else if (r_state == BS_WALK && !w_stall) begin
            if (r_dv) begin
                if (w_crossed) begin
                    if (r_prev_x) begin
                        n_run_len = r_run_len + RunW'(1);
                    end else begin
                        n_run_start = StartW'(r_cur);
                        n_run_len   = RunW'(1);
                    end
                end
                n_prev_x = w_crossed;
            end
            n_dv = w_rd_en;
            if (w_rd_en) begin
                n_cur     = r_rd_page;
                n_rd_page = r_rd_page + WalkW'(1);
                n_rd_left = r_rd_left - RunW'(1);
            end
        end
    end

    // Count table.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[AW'(r_rd_page)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_CLEAR;
            r_clr    <= '0;
            r_dv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            r_dv <= n_dv;
            if (w_emit && w_emit_ok) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_page   <= n_rd_page;
        r_rd_left   <= n_rd_left;
        r_cur       <= n_cur;
        r_op        <= n_op;
        r_status    <= n_status;
        r_run_start <= n_run_start;
        r_run_len   <= n_run_len;
        r_prev_x    <= n_prev_x;
        if (w_emit && w_emit_ok) begin
            r_o_start  <= w_e_start;
            r_o_pages  <= w_e_pages;
            r_o_status <= w_e_status;
            r_o_last   <= w_e_last;
        end
    end

    assign o_empty     = !r_ov;
    assign o_run_start = r_o_start;
    assign o_run_pages = r_o_pages;
    assign o_status    = r_o_status;
    assign o_last      = r_o_last;

endmodule

[rtl/page_range_refcount_tracker.sv]
// Top level of the page range reference count tracker: front classifier and
// back walker with the count table. Depends on prrt_pkg, prrt_front, prrt_back.
//
//  channel   direction  handshake              payload
//  request   in         i_push / o_full        i_command, i_start_page, i_length_bytes
//  result    out        o_empty / i_pop        o_run_start, o_run_pages, o_status, o_last
//
// The walk reads and writes one table entry per cycle, unless a held result
// stalls it, through one read and one write port. Two classified requests
// can wait in the queue between front and back while a walk runs.
// After reset the table is cleared one entry per cycle, with o_full high.
// A held result stalls the walk only when a new run is due.
module page_range_refcount_tracker #(
    parameter int unsigned PAGE_BITS       = prrt_pkg::DefPageBits,
    parameter int unsigned TRACKED_PAGES   = prrt_pkg::DefTrackedPages,
    parameter int unsigned MAX_RANGE_PAGES = prrt_pkg::DefMaxRangePages,
    parameter int unsigned COUNT_BITS      = prrt_pkg::DefCountBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_command,
    input  logic [prrt_pkg::StartW-1:0]   i_start_page,
    input  logic [prrt_pkg::LenW-1:0]     i_length_bytes,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [prrt_pkg::StartW-1:0]   o_run_start,
    output logic [prrt_pkg::RunW-1:0]     o_run_pages,
    output logic [1:0]                    o_status,
    output logic                          o_last
);
    import prrt_pkg::*;

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;
    logic w_clearing;

    prrt_front #(
        .PAGE_BITS       (PAGE_BITS),
        .TRACKED_PAGES   (TRACKED_PAGES),
        .MAX_RANGE_PAGES (MAX_RANGE_PAGES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_command      (i_command),
        .i_start_page   (i_start_page),
        .i_length_bytes (i_length_bytes),
        .i_hold         (w_clearing),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_pop      (w_cmd_pop)
    );

    prrt_back #(
        .TRACKED_PAGES (TRACKED_PAGES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_clearing  (w_clearing),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_run_start (o_run_start),
        .o_run_pages (o_run_pages),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

[rtl/prrt_checker.sv]
// Port-level checks for the page range reference count tracker, bound to the
// top level. Depends on prrt_pkg and page_range_refcount_tracker.
module prrt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          o_full,
    input  logic                          i_command,
    input  logic [prrt_pkg::StartW-1:0]   i_start_page,
    input  logic [prrt_pkg::LenW-1:0]     i_length_bytes,
    input  logic                          o_empty,
    input  logic                          i_pop,
    input  logic [prrt_pkg::StartW-1:0]   o_run_start,
    input  logic [prrt_pkg::RunW-1:0]     o_run_pages,
    input  logic [1:0]                    o_status,
    input  logic                          o_last
);
    import prrt_pkg::*;

    // Table clear holds off requests and no result is pending out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> o_full && o_empty)
        else $error("full/empty wrong after reset");

    // A waiting result holds until taken.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_run_start)
            && $stable(o_run_pages) && $stable(o_status) && $stable(o_last))
        else $error("result changed while stalled");

    // Only the final transaction of a request may be empty or carry an error.
    a_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_last |-> o_run_pages != '0 && o_status == ST_OK)
        else $error("non-final result malformed");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_status != ST_OK |-> o_last && o_run_pages == '0
            && o_run_start == '0)
        else $error("error result malformed");

endmodule

bind page_range_refcount_tracker prrt_checker u_prrt_checker (.*);

[bench/prrt_run_checker.sv]
`timescale 1ns / 100ps
// Checker for the page range reference count tracker: watches the request and
// result channels, predicts the runs of each request and compares. Uses prrt_pkg.
module prrt_run_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_full,
    input  logic                        i_command,
    input  logic [prrt_pkg::StartW-1:0] i_start_page,
    input  logic [prrt_pkg::LenW-1:0]   i_length_bytes,
    input  logic                        i_empty,
    input  logic                        i_pop,
    input  logic [prrt_pkg::StartW-1:0] i_run_start,
    input  logic [prrt_pkg::RunW-1:0]   i_run_pages,
    input  logic [1:0]                  i_status,
    input  logic                        i_last,
    output int                          o_fail_count,
    output int                          o_pending
);
    import prrt_pkg::*;

    localparam int unsigned PageSize  = 1 << DefPageBits;
    localparam int unsigned RunLimit  = 64;
    localparam int          CountMax  = (1 << (DefCountBits - 1)) - 1;
    localparam int          CountMin  = -CountMax - 1;

    typedef struct packed {
        logic [StartW-1:0] run_start;
        logic [RunW-1:0]   run_pages;
        t_status           status;
        logic              last;
    } t_run_result;

    logic signed [DefCountBits-1:0] page_count [DefTrackedPages];
    t_run_result                    expected_runs [$];
    t_run_result                    oldest_run;

    // Apply one request to the page table and queue the runs it must report.
    task automatic predict_runs(input t_cmd_op op, input logic [StartW-1:0] first,
                                input logic [LenW-1:0] nbytes);
        int unsigned npages;
        int unsigned pg;
        int unsigned run_first;
        int unsigned run_len;
        int unsigned held;
        int          old_cnt;
        int          new_cnt;
        if (nbytes == '0) begin
            expected_runs.push_back(t_run_result'{'0, '0, ST_ZERO_LEN, 1'b1});
            return;
        end
        npages = (32'(nbytes) + PageSize - 1) >> DefPageBits;
        if (npages > DefMaxRangePages || 32'(first) + npages > DefTrackedPages) begin
            expected_runs.push_back(t_run_result'{'0, '0, ST_RANGE, 1'b1});
            return;
        end
        run_first = 0;
        run_len   = 0;
        held      = 0;
        for (pg = 32'(first); pg < 32'(first) + npages; pg++) begin
            old_cnt = page_count[pg];
            new_cnt = (op == CMD_RELEASE) ? old_cnt - 1 : old_cnt + 1;
            if (new_cnt > CountMax) begin
                new_cnt = CountMax;
            end
            if (new_cnt < CountMin) begin
                new_cnt = CountMin;
            end
            page_count[pg] = new_cnt[DefCountBits-1:0];
            if ((old_cnt == 0 && new_cnt == 1) || (old_cnt == 1 && new_cnt == 0)) begin
                if (run_len != 0 && run_first + run_len == pg) begin
                    run_len++;
                end else begin
                    // past the result cap only the final run survives
                    if (run_len != 0 && held < RunLimit - 1) begin
                        expected_runs.push_back(t_run_result'{StartW'(run_first),
                                                RunW'(run_len), ST_OK, 1'b0});
                        held++;
                    end
                    run_first = pg;
                    run_len   = 1;
                end
            end
        end
        expected_runs.push_back(t_run_result'{StartW'(run_first), RunW'(run_len),
                                              ST_OK, 1'b1});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (page_count[pg]) begin
                page_count[pg] = '0;
            end
            expected_runs.delete();
            o_fail_count = 0;
        end else begin
            // compare before predicting: a result never belongs to the request
            // accepted at the same edge
            if (i_pop && !i_empty) begin
                if (expected_runs.size() == 0) begin
                    $error("result with no request pending: run_start %0d run_pages %0d",
                           i_run_start, i_run_pages);
                    o_fail_count++;
                end else begin
                    oldest_run = expected_runs.pop_front();
                    if (i_run_start !== oldest_run.run_start) begin
                        $error("run_start mismatch: expected %0d, actual %0d",
                               oldest_run.run_start, i_run_start);
                        o_fail_count++;
                    end
                    if (i_run_pages !== oldest_run.run_pages) begin
                        $error("run_pages mismatch: expected %0d, actual %0d",
                               oldest_run.run_pages, i_run_pages);
                        o_fail_count++;
                    end
                    if (i_status !== oldest_run.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest_run.status, i_status);
                        o_fail_count++;
                    end
                    if (i_last !== oldest_run.last) begin
                        $error("last mismatch: expected %0d, actual %0d",
                               oldest_run.last, i_last);
                        o_fail_count++;
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_runs(t_cmd_op'(i_command), i_start_page, i_length_bytes);
            end
        end
        o_pending = expected_runs.size();
    end

endmodule

[bench/page_range_refcount_tracker_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the page range reference count tracker: clock, reset,
// request and pop stimulus, watchdog and verdict. Uses prrt_pkg and prrt_run_checker.
module page_range_refcount_tracker_tb;
    import prrt_pkg::*;

    localparam int unsigned HoldOffCycles = 400;
    localparam int unsigned IdleLimit     = 12000;
    localparam int unsigned DrainCycles   = 300;
    localparam int unsigned RandomItems   = 130;
    localparam int unsigned PageSize      = 1 << DefPageBits;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_push;
    logic              o_full;
    logic              i_command;
    logic [StartW-1:0] i_start_page;
    logic [LenW-1:0]   i_length_bytes;
    logic              o_empty;
    logic              i_pop;
    logic [StartW-1:0] o_run_start;
    logic [RunW-1:0]   o_run_pages;
    logic [1:0]        o_status;
    logic              o_last;

    int                fail_count;
    int                pending;
    int unsigned       idle_cycles;
    bit                steady_traffic;
    bit                hold_off_req;

    page_range_refcount_tracker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_command      (i_command),
        .i_start_page   (i_start_page),
        .i_length_bytes (i_length_bytes),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_run_start    (o_run_start),
        .o_run_pages    (o_run_pages),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    prrt_run_checker run_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_full         (o_full),
        .i_command      (i_command),
        .i_start_page   (i_start_page),
        .i_length_bytes (i_length_bytes),
        .i_empty        (o_empty),
        .i_pop          (i_pop),
        .i_run_start    (o_run_start),
        .i_run_pages    (o_run_pages),
        .i_status       (o_status),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offer one request from a falling edge; return at the falling edge after
    // the transaction is taken.
    task automatic send_request(input t_cmd_op op, input logic [StartW-1:0] first,
                                input logic [LenW-1:0] nbytes);
        int gap;
        if (!steady_traffic && $urandom_range(99) < 8) begin
            gap = int'($urandom_range(1, 2));
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push         <= 1'b1;
        i_command      <= op;
        i_start_page   <= first;
        i_length_bytes <= nbytes;
        do @(posedge i_clk); while (o_full);
        @(negedge i_clk);
    endtask

    // Hold requests until every predicted run has been popped.
    task automatic wait_drained();
        i_push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // Result side: random pops, one long hold-off on request.
    initial begin
        bit held_off;
        held_off = 1'b0;
        i_pop    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !held_off) begin
                i_pop <= 1'b0;
                repeat (HoldOffCycles) @(negedge i_clk);
                held_off = 1'b1;
            end
            i_pop <= steady_traffic || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int                sel;
        int unsigned       k;
        t_cmd_op           op;
        logic [StartW-1:0] first;
        logic [LenW-1:0]   nbytes;

        i_rst_n        = 1'b0;
        i_push         = 1'b0;
        i_command      = CMD_OCCUPY;
        i_start_page   = '0;
        i_length_bytes = '0;
        steady_traffic = 1'b0;
        hold_off_req   = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, errors, rounding, negative counts, split runs
        send_request(CMD_OCCUPY,  12'd4095, 20'd0);
        send_request(CMD_RELEASE, 12'd0,    20'd0);
        send_request(CMD_OCCUPY,  12'd0,    20'd524288);
        send_request(CMD_RELEASE, 12'd0,    20'd524288);
        send_request(CMD_OCCUPY,  12'd4095, 20'd1);
        send_request(CMD_OCCUPY,  12'd4088, 20'd32768);
        send_request(CMD_OCCUPY,  12'd4089, 20'd32768);
        send_request(CMD_OCCUPY,  12'd4095, 20'd8192);
        send_request(CMD_RELEASE, 12'd4088, 20'd32768);
        send_request(CMD_RELEASE, 12'd4095, 20'd4096);
        send_request(CMD_RELEASE, 12'd4095, 20'd1);
        send_request(CMD_OCCUPY,  12'd4095, 20'd4095);
        send_request(CMD_OCCUPY,  12'd4095, 20'd1);
        send_request(CMD_OCCUPY,  12'd100,  20'd8192);
        send_request(CMD_OCCUPY,  12'd96,   20'd65536);
        send_request(CMD_OCCUPY,  12'd200,  20'd4097);
        send_request(CMD_RELEASE, 12'd200,  20'd8191);
        send_request(CMD_OCCUPY,  12'd300,  20'd4095);
        send_request(CMD_RELEASE, 12'd96,   20'd65536);
        send_request(CMD_RELEASE, 12'd300,  20'd1);
        send_request(CMD_OCCUPY,  12'hAAA,  20'h55555);
        send_request(CMD_RELEASE, 12'h555,  20'h2AAAA);
        send_request(CMD_OCCUPY,  12'h555,  20'h2AAAA);
        send_request(CMD_RELEASE, 12'hAAA,  20'h55555);
        wait_drained();

        // comb: every other page held once, then a full range splits into
        // the most runs one request can report
        for (k = 0; k < 64; k++) begin
            send_request(CMD_OCCUPY, StartW'(512 + 2 * k), 20'd1);
        end
        send_request(CMD_OCCUPY,  12'd512, 20'd524288);
        send_request(CMD_RELEASE, 12'd512, 20'd524288);
        wait_drained();

        // random: mostly short ranges in a small window so counts keep crossing
        hold_off_req = 1'b1;
        for (k = 0; k < RandomItems; k++) begin
            steady_traffic = (k >= 40 && k < 90);
            if (k == 100) begin
                wait_drained();
            end
            sel = int'($urandom_range(99));
            op  = ($urandom_range(99) < 55) ? CMD_OCCUPY : CMD_RELEASE;
            if (sel < 4) begin
                first  = StartW'($urandom_range(4095));
                nbytes = '0;
            end else if (sel < 10) begin
                first  = StartW'($urandom_range(4095));
                nbytes = LenW'($urandom_range(524288, 1));
            end else if (sel < 18) begin
                first  = StartW'($urandom_range(255));
                nbytes = LenW'($urandom_range(524288, 1));
            end else begin
                first  = StartW'($urandom_range(255));
                nbytes = LenW'($urandom_range(16 * PageSize, 1));
            end
            send_request(op, first, nbytes);
        end
        steady_traffic = 1'b0;
        i_push <= 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/prrt_pkg.sv
rtl/prrt_front.sv
rtl/prrt_back.sv
rtl/page_range_refcount_tracker.sv
rtl/prrt_checker.sv
bench/prrt_run_checker.sv
bench/page_range_refcount_tracker_tb.sv
